// ===== rtl/servo_teach_playback_stepper_core_defines.svh =====
// ----------------------------------------------------------------------------
// Servo teach-and-playback stepper: assertion macros
// Shared property forms for the checker, sampled on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_TEACH_PLAYBACK_STEPPER_CORE_DEFINES_SVH
`define SERVO_TEACH_PLAYBACK_STEPPER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STPB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo teach-and-playback stepper: package
// Sizes, function codes, direction codes and the structs shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stpb_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int AXES        = 3;
    localparam int IN_AXES     = 3;
    localparam int OUT_AXES    = (AXES < IN_AXES) ? AXES : IN_AXES;

    localparam int PULSE_W    = 12;
    localparam int VEL_W      = 8;
    localparam int FUNC_W     = 3;
    localparam int ENTRY_W    = 6;
    localparam int RECORDED_W = 7;
    localparam int STEP_W     = 13;
    localparam int DIR_W      = 2;
    localparam int SLOT_W     = $clog2(TABLE_SLOTS + 1);
    localparam int ADDR_W     = $clog2(TABLE_SLOTS);
    localparam int AXIS_W     = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int WORD_W     = AXES * PULSE_W;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [PULSE_W-1:0] HOME_RESET = PULSE_W'(1500);
    localparam logic [VEL_W-1:0]   VEL_RESET  = VEL_W'(1);

    localparam logic [FUNC_W-1:0] FUNC_DRIVE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RECORD = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PLAY   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd4;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_VELOCITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_PULSE    = 1'd1;

    typedef logic [PULSE_W-1:0] pulse_t;

    typedef enum logic {
        ALU_PLAN,
        ALU_STEP
    } alu_op_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        pulse_t [IN_AXES-1:0]     pulse;
        logic [ENTRY_W-1:0]       entry;
    } item_t;

    typedef struct packed {
        logic [VEL_W-1:0] velocity;
        logic             home_load;
        pulse_t           home;
    } cfg_t;

    typedef struct packed {
        pulse_t [IN_AXES-1:0]     pos;
        logic                     moving;
        logic [RECORDED_W-1:0]    recorded;
        logic                     table_full;
    } status_t;

    typedef struct packed {
        alu_op_t            op;
        pulse_t             from;
        pulse_t             to;
        logic [STEP_W-1:0]  step;
        pulse_t             span;
        logic [DIR_W-1:0]   dir;
        pulse_t             longest;
    } alu_in_t;

    typedef struct packed {
        logic [DIR_W-1:0]   dir;
        pulse_t             span;
        pulse_t             longest;
        pulse_t             pos;
    } alu_out_t;

endpackage

// ===== rtl/stpb_axis_alu.sv =====
// ----------------------------------------------------------------------------
// Servo teach-and-playback stepper: shared axis unit
// Plans one axis of a move (direction, distance, running maximum) or steps one
// axis along it. The sequencer walks the axes through this unit one at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpb_axis_alu
(
    input  stpb_pkg::alu_in_t  alu_in,
    output stpb_pkg::alu_out_t alu_out
);
    import stpb_pkg::*;

    logic [PULSE_W:0] diff;
    logic [PULSE_W:0] neg_diff;
    pulse_t           travel;

    always_comb
    begin
        diff     = {1'b0, alu_in.to} - {1'b0, alu_in.from};
        neg_diff = '0 - diff;
        travel   = '0;
        alu_out  = '0;
        alu_out.longest = alu_in.longest;
        alu_out.pos     = alu_in.from;
        case (alu_in.op)
            ALU_PLAN:
            begin
                if (diff == '0)
                begin
                    alu_out.dir  = DIR_NONE;
                    alu_out.span = '0;
                end
                else if (diff[PULSE_W])
                begin
                    alu_out.dir  = DIR_DOWN;
                    alu_out.span = neg_diff[PULSE_W-1:0];
                end
                else
                begin
                    alu_out.dir  = DIR_UP;
                    alu_out.span = diff[PULSE_W-1:0];
                end
                if (alu_out.span > alu_in.longest)
                begin
                    alu_out.longest = alu_out.span;
                end
            end
            ALU_STEP:
            begin
                // Travel so far is capped at this axis's own distance.
                if (alu_in.step < STEP_W'(alu_in.span))
                begin
                    travel = alu_in.step[PULSE_W-1:0];
                end
                else
                begin
                    travel = alu_in.span;
                end
                alu_out.dir  = alu_in.dir;
                alu_out.span = alu_in.span;
                if (alu_in.dir == DIR_UP)
                begin
                    alu_out.pos = alu_in.from + travel;
                end
                else if (alu_in.dir == DIR_DOWN)
                begin
                    alu_out.pos = alu_in.from - travel;
                end
            end
            default:
            begin
                alu_out.pos = alu_in.from;
            end
        endcase
    end

endmodule

// ===== rtl/stpb_seq.sv =====
// ----------------------------------------------------------------------------
// Servo teach-and-playback stepper: sequencer
// Holds the axis state and the pose table and runs play and tick items through
// the shared axis unit, one axis per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpb_seq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  stpb_pkg::item_t  item,
    input  stpb_pkg::cfg_t   cfg,
    input  logic             out_free,
    output logic             idle,
    output logic             res_valid,
    output stpb_pkg::status_t status
);
    import stpb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_READ,
        S_PLAN,
        S_PLAN_END,
        S_STEP,
        S_STEP_END,
        S_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    pulse_t                  live_reg   [AXES];
    pulse_t                  live_next  [AXES];
    pulse_t                  rest_reg   [AXES];
    pulse_t                  rest_next  [AXES];
    pulse_t                  target_reg [AXES];
    pulse_t                  target_next[AXES];
    pulse_t                  dist_reg   [AXES];
    pulse_t                  dist_next  [AXES];
    logic [DIR_W-1:0]        dir_reg    [AXES];
    logic [DIR_W-1:0]        dir_next   [AXES];
    logic [STEP_W-1:0]       step_reg, step_next;
    pulse_t                  longest_reg, longest_next;
    logic                    busy_reg, busy_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic                    full_reg, full_next;
    logic [AXIS_W-1:0]       axis_reg, axis_next;
    logic [ADDR_W-1:0]       fill_reg, fill_next;
    logic [ADDR_W-1:0]       entry_reg;

    logic [WORD_W-1:0]       mem [TABLE_SLOTS];
    logic [WORD_W-1:0]       mem_q;
    logic [WORD_W-1:0]       mem_wdata;
    logic [ADDR_W-1:0]       mem_waddr;
    logic                    mem_we;

    alu_in_t                 alu_in;
    alu_out_t                alu_out;
    logic [STEP_W-1:0]       step_sum;
    logic                    last_axis;

    stpb_axis_alu u_alu
    (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            mem_wdata[a*PULSE_W +: PULSE_W] = live_reg[a];
        end
        mem_waddr = (state_reg == S_FILL) ? fill_reg : slot_reg[ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[entry_reg];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            entry_reg <= ADDR_W'(item.entry);
        end
    end

    always_comb
    begin
        alu_in.op      = (state_reg == S_STEP) ? ALU_STEP : ALU_PLAN;
        alu_in.from    = rest_reg[axis_reg];
        alu_in.to      = mem_q[axis_reg*PULSE_W +: PULSE_W];
        alu_in.step    = step_reg;
        alu_in.span    = dist_reg[axis_reg];
        alu_in.dir     = dir_reg[axis_reg];
        alu_in.longest = longest_reg;
        step_sum       = step_reg + STEP_W'(cfg.velocity);
        last_axis      = (axis_reg == AXIS_W'(AXES - 1));
    end

    always_comb
    begin
        state_next   = state_reg;
        live_next    = live_reg;
        rest_next    = rest_reg;
        target_next  = target_reg;
        dist_next    = dist_reg;
        dir_next     = dir_reg;
        step_next    = step_reg;
        longest_next = longest_reg;
        busy_next    = busy_reg;
        slot_next    = slot_reg;
        full_next    = full_reg;
        axis_next    = axis_reg;
        fill_next    = fill_reg;
        mem_we       = 1'b0;
        res_valid    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    full_next  = 1'b0;
                    state_next = S_FINISH;
                    case (item.func)
                        FUNC_DRIVE:
                        begin
                            if (!busy_reg)
                            begin
                                for (int a = 0; a < AXES; a++)
                                begin
                                    live_next[a] = item.pulse[(a < IN_AXES - 1) ? a : IN_AXES - 1];
                                end
                            end
                        end
                        FUNC_RECORD:
                        begin
                            if (slot_reg >= SLOT_W'(TABLE_SLOTS))
                            begin
                                full_next = 1'b1;
                            end
                            else if (slot_reg == '0)
                            begin
                                // The first record after a clear fills the whole table.
                                fill_next  = '0;
                                state_next = S_FILL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                slot_next = slot_reg + SLOT_W'(1);
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            slot_next = '0;
                        end
                        FUNC_PLAY:
                        begin
                            if (!busy_reg && (int'(item.entry) < TABLE_SLOTS))
                            begin
                                if (item.entry == '0)
                                begin
                                    rest_next = live_reg;
                                end
                                longest_next = '0;
                                axis_next    = '0;
                                state_next   = S_READ;
                            end
                        end
                        FUNC_TICK:
                        begin
                            if (busy_reg)
                            begin
                                axis_next  = '0;
                                state_next = S_STEP;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                fill_next = fill_reg + ADDR_W'(1);
                if (fill_reg == ADDR_W'(TABLE_SLOTS - 1))
                begin
                    slot_next  = SLOT_W'(1);
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                state_next = S_PLAN;
            end
            S_PLAN:
            begin
                target_next[axis_reg] = alu_in.to;
                dir_next[axis_reg]    = alu_out.dir;
                dist_next[axis_reg]   = alu_out.span;
                longest_next          = alu_out.longest;
                axis_next             = axis_reg + AXIS_W'(1);
                if (last_axis)
                begin
                    state_next = S_PLAN_END;
                end
            end
            S_PLAN_END:
            begin
                step_next  = STEP_W'(1);
                state_next = S_FINISH;
                if (longest_reg == '0)
                begin
                    for (int a = 0; a < AXES; a++)
                    begin
                        live_next[a] = target_reg[a];
                        rest_next[a] = target_reg[a];
                    end
                    busy_next = 1'b0;
                end
                else
                begin
                    busy_next = 1'b1;
                end
            end
            S_STEP:
            begin
                if (dir_reg[axis_reg] != DIR_NONE)
                begin
                    live_next[axis_reg] = alu_out.pos;
                end
                axis_next = axis_reg + AXIS_W'(1);
                if (last_axis)
                begin
                    state_next = S_STEP_END;
                end
            end
            S_STEP_END:
            begin
                step_next  = step_sum;
                state_next = S_FINISH;
                // Past the longest distance every axis lands exactly on its target.
                if (step_sum > STEP_W'(longest_reg))
                begin
                    for (int a = 0; a < AXES; a++)
                    begin
                        live_next[a] = target_reg[a];
                        rest_next[a] = target_reg[a];
                    end
                    busy_next = 1'b0;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.home_load)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                live_next[a] = cfg.home;
                rest_next[a] = cfg.home;
            end
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            for (int a = 0; a < AXES; a++)
            begin
                live_reg[a]   <= HOME_RESET;
                rest_reg[a]   <= HOME_RESET;
                target_reg[a] <= '0;
                dist_reg[a]   <= '0;
                dir_reg[a]    <= DIR_NONE;
            end
            step_reg    <= '0;
            longest_reg <= '0;
            busy_reg    <= 1'b0;
            slot_reg    <= '0;
            full_reg    <= 1'b0;
            axis_reg    <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            live_reg    <= live_next;
            rest_reg    <= rest_next;
            target_reg  <= target_next;
            dist_reg    <= dist_next;
            dir_reg     <= dir_next;
            step_reg    <= step_next;
            longest_reg <= longest_next;
            busy_reg    <= busy_next;
            slot_reg    <= slot_next;
            full_reg    <= full_next;
            axis_reg    <= axis_next;
            fill_reg    <= fill_next;
        end
    end

    always_comb
    begin
        status = '0;
        for (int i = 0; i < OUT_AXES; i++)
        begin
            status.pos[i] = live_reg[i];
        end
        status.moving     = busy_reg;
        status.recorded   = RECORDED_W'(slot_reg);
        status.table_full = full_reg;
        idle              = (state_reg == S_IDLE);
    end

endmodule

// ===== rtl/servo_teach_playback_stepper_core.sv =====
// ----------------------------------------------------------------------------
// Servo teach-and-playback stepper: top level
// Stream ports, configuration registers and the result register.
// ----------------------------------------------------------------------------
// Each accepted word returns one result word with the three live pulse widths,
// the moving flag, the recorded slot count and the table-full flag. The block
// takes one word at a time. A tick and a play walk the shared axis unit one
// axis per cycle, and the first record after a clear fills the pose table
// through its single write port, one slot per cycle. A new word is taken
// while the last result still waits in the output register.
`timescale 1ns / 1ps

module servo_teach_playback_stepper_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pulse_a [11:0], pulse_b [23:12], pulse_c [35:24], entry [41:36]
    input  logic [stpb_pkg::IN_DATA_W-1:0]     s_tdata,
    // func [2:0]
    input  logic [stpb_pkg::FUNC_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_a [11:0], out_b [23:12], out_c [35:24], moving [36],
    // recorded [43:37], table_full [44]
    output logic [stpb_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [stpb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stpb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import stpb_pkg::*;

    logic [VEL_W-1:0]        velocity_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [OUT_DATA_W-1:0]   result_word;
    logic                    cfg_write;
    logic                    start;
    logic                    out_free;
    logic                    seq_idle;
    logic                    res_valid;
    item_t                   item;
    cfg_t                    cfg;
    status_t                 status;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_tready  = seq_idle;
    assign start     = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        item.func = s_tuser;
        for (int i = 0; i < IN_AXES; i++)
        begin
            item.pulse[i] = s_tdata[i*PULSE_W +: PULSE_W];
        end
        item.entry = s_tdata[IN_AXES*PULSE_W +: ENTRY_W];

        // A zero velocity moves like a velocity of one.
        cfg.velocity  = (velocity_reg == '0) ? VEL_W'(1) : velocity_reg;
        cfg.home_load = cfg_write && (cfg_index == CFG_HOME_PULSE);
        cfg.home      = cfg_data[PULSE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_reg <= VEL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_STEP_VELOCITY:
                begin
                    velocity_reg <= cfg_data[VEL_W-1:0];
                end
                default:
                begin
                    velocity_reg <= velocity_reg;
                end
            endcase
        end
    end

    stpb_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg       (cfg),
        .out_free  (out_free),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .status    (status)
    );

    always_comb
    begin
        result_word = '0;
        for (int i = 0; i < IN_AXES; i++)
        begin
            result_word[i*PULSE_W +: PULSE_W] = status.pos[i];
        end
        result_word[IN_AXES*PULSE_W]                      = status.moving;
        result_word[IN_AXES*PULSE_W + 1 +: RECORDED_W]    = status.recorded;
        result_word[IN_AXES*PULSE_W + 1 + RECORDED_W]     = status.table_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_tdata_reg <= result_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/stpb_checker.sv =====
// ----------------------------------------------------------------------------
// Servo teach-and-playback stepper: port checker
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "servo_teach_playback_stepper_core_defines.svh"

module stpb_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [stpb_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import stpb_pkg::*;

    // Every word moves the sequencer out of idle, so ready must drop after acceptance.
    `STPB_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready stayed high after a word was taken")

    // The slot count never passes the table size.
    `STPB_ASSERT_SAME(a_recorded_range, m_tvalid, m_tdata[43:37] <= 7'd64, "recorded count beyond table size")

    // A rejected record only happens with a full table.
    `STPB_ASSERT_SAME(a_full_means_64, m_tvalid && m_tdata[44], m_tdata[43:37] == 7'd64, "table full flagged below table size")

    // A stalled result word holds.
    `STPB_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result word changed")

endmodule

bind servo_teach_playback_stepper_core stpb_checker u_stpb_checker (.*);
